[hw/rtl/pwg_pkg.sv]
// ----------------------------------------------------------------------------
// Pulse waveform generator package
// Shared widths, register indexes, region codes and pipeline word types.
// ----------------------------------------------------------------------------
package pwg_pkg;

    localparam int TIME_BITS  = 32;
    localparam int LEVEL_BITS = 16;
    localparam int MAG_BITS   = LEVEL_BITS + 1;
    localparam int CFG_BITS   = 32;
    localparam int IDX_BITS   = 3;

    typedef enum logic [IDX_BITS-1:0] {
        REG_BASE_LEVEL   = 3'd0,
        REG_PEAK_LEVEL   = 3'd1,
        REG_START_DELAY  = 3'd2,
        REG_RISE_TICKS   = 3'd3,
        REG_WIDTH_TICKS  = 3'd4,
        REG_FALL_TICKS   = 3'd5,
        REG_PERIOD_TICKS = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        REGION_DELAY   = 3'd0,
        REGION_RISING  = 3'd1,
        REGION_HIGH    = 3'd2,
        REGION_FALLING = 3'd3,
        REGION_REST    = 3'd4
    } region_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] start_delay;
        logic [TIME_BITS-1:0] rise_ticks;
        logic [TIME_BITS-1:0] width_ticks;
        logic [TIME_BITS-1:0] fall_ticks;
        logic [TIME_BITS-1:0] period_ticks;
        logic [LEVEL_BITS-1:0] base_level;
        logic [LEVEL_BITS-1:0] peak_level;
    } cfg_t;

    typedef struct packed {
        logic                 pre_delay;
        logic [TIME_BITS-1:0] ph;
        logic [TIME_BITS-1:0] dvd;
        logic [TIME_BITS-1:0] rem;
    } wrap_word_t;

    typedef struct packed {
        region_t                region;
        logic [TIME_BITS-1:0]   dur;
        logic [LEVEL_BITS-1:0]  from;
        logic                   neg;
        logic [TIME_BITS-1:0]   rem;
        logic [MAG_BITS-1:0]    low;
        logic [MAG_BITS-1:0]    quo;
    } div_word_t;

endpackage

[hw/rtl/pwg_wrap.sv]
// ----------------------------------------------------------------------------
// Phase wrap pipeline
// Restoring remainder of the phase by the period, one bit per stage.
// ----------------------------------------------------------------------------
module pwg_wrap (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  pwg_pkg::cfg_t                  cfg,
    input  logic                           in_valid,
    input  logic                           in_before,
    input  logic [pwg_pkg::TIME_BITS-1:0]  in_ph,
    output logic                           out_valid,
    output logic                           out_before,
    output logic [pwg_pkg::TIME_BITS-1:0]  out_phase
);

    localparam int TB = pwg_pkg::TIME_BITS;

    pwg_pkg::wrap_word_t in_word;
    pwg_pkg::wrap_word_t word_reg [1:TB];
    logic                valid_reg [1:TB];

    always_comb begin
        in_word.pre_delay = in_before;
        in_word.ph        = in_ph;
        in_word.dvd       = in_ph;
        in_word.rem       = '0;
    end

    for (genvar i = 0; i < TB; i++) begin : g_step
        logic [TB:0]         tmp;
        pwg_pkg::wrap_word_t word_cur;
        logic                valid_cur;
        pwg_pkg::wrap_word_t word_next;

        if (i == 0) begin : g_head
            assign word_cur  = in_word;
            assign valid_cur = in_valid;
        end else begin : g_body
            assign word_cur  = word_reg[i];
            assign valid_cur = valid_reg[i];
        end

        always_comb begin
            tmp       = {word_cur.rem, word_cur.dvd[TB-1]};
            word_next = word_cur;
            word_next.dvd = {word_cur.dvd[TB-2:0], 1'b0};
            if (tmp >= {1'b0, cfg.period_ticks}) begin
                word_next.rem = TB'(tmp - {1'b0, cfg.period_ticks});
            end else begin
                word_next.rem = tmp[TB-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i+1] <= 1'b0;
            end else if (en) begin
                valid_reg[i+1] <= valid_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                word_reg[i+1] <= word_next;
            end
        end
    end

    assign out_valid  = valid_reg[TB];
    assign out_before = word_reg[TB].pre_delay;
    assign out_phase  = (cfg.period_ticks == '0) ? word_reg[TB].ph : word_reg[TB].rem;

endmodule

[hw/rtl/pwg_ramp.sv]
// ----------------------------------------------------------------------------
// Region decode and ramp pipeline
// Finds the region of a phase, then forms from + diff * t / dur with a
// multiply stage and a restoring divider of one quotient bit per stage.
// ----------------------------------------------------------------------------
module pwg_ramp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  pwg_pkg::cfg_t                   cfg,
    input  logic                            in_valid,
    input  logic                            in_before,
    input  logic [pwg_pkg::TIME_BITS-1:0]   in_phase,
    output logic                            out_valid,
    output logic [pwg_pkg::LEVEL_BITS-1:0]  out_level,
    output pwg_pkg::region_t                out_region
);

    localparam int TB = pwg_pkg::TIME_BITS;
    localparam int LB = pwg_pkg::LEVEL_BITS;
    localparam int MB = pwg_pkg::MAG_BITS;

    // Stage A: compare against the rise length.
    logic          a_valid_reg;
    logic          a_before_reg;
    logic          a_lt_rise_reg;
    logic [TB-1:0] a_ph_reg;
    logic [TB-1:0] a_p1_reg;

    // Stage B: compare against the width.
    logic          b_valid_reg;
    logic          b_before_reg;
    logic          b_lt_rise_reg;
    logic          b_lt_width_reg;
    logic [TB-1:0] b_ph_reg;
    logic [TB-1:0] b_p2_reg;

    // Stage C: region and ramp operands.
    logic          c_valid_reg;
    pwg_pkg::region_t c_region_reg;
    logic [TB-1:0] c_t_reg;
    logic [TB-1:0] c_dur_reg;
    logic [LB-1:0] c_from_reg;
    logic          c_neg_reg;
    logic [MB-1:0] c_mag_reg;

    pwg_pkg::region_t c_region_next;
    logic [TB-1:0]    c_t_next;
    logic [TB-1:0]    c_dur_next;
    logic [LB-1:0]    c_from_next;
    logic             c_neg_next;
    logic [MB-1:0]    c_mag_next;
    logic signed [MB-1:0] diff;
    logic [LB-1:0]    to_lvl;
    logic             is_ramp;

    // Stage D: product.
    logic             d_valid_reg;
    pwg_pkg::div_word_t d_word_reg;

    pwg_pkg::div_word_t word_reg [1:MB];
    logic               valid_reg [1:MB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_before_reg   <= in_before;
            a_lt_rise_reg  <= in_phase < cfg.rise_ticks;
            a_ph_reg       <= in_phase;
            a_p1_reg       <= in_phase - cfg.rise_ticks;
            b_before_reg   <= a_before_reg;
            b_lt_rise_reg  <= a_lt_rise_reg;
            b_lt_width_reg <= a_p1_reg < cfg.width_ticks;
            b_ph_reg       <= a_ph_reg;
            b_p2_reg       <= a_p1_reg - cfg.width_ticks;
        end
    end

    always_comb begin
        c_t_next    = '0;
        c_dur_next  = TB'(1);
        c_from_next = cfg.base_level;
        to_lvl      = cfg.base_level;
        is_ramp     = 1'b0;
        if (b_before_reg) begin
            c_region_next = pwg_pkg::REGION_DELAY;
        end else if (b_lt_rise_reg) begin
            c_region_next = pwg_pkg::REGION_RISING;
            c_t_next      = b_ph_reg;
            c_dur_next    = cfg.rise_ticks;
            to_lvl        = cfg.peak_level;
            is_ramp       = 1'b1;
        end else if (b_lt_width_reg) begin
            c_region_next = pwg_pkg::REGION_HIGH;
            c_from_next   = cfg.peak_level;
        end else if (b_p2_reg < cfg.fall_ticks) begin
            c_region_next = pwg_pkg::REGION_FALLING;
            c_t_next      = b_p2_reg;
            c_dur_next    = cfg.fall_ticks;
            c_from_next   = cfg.peak_level;
            to_lvl        = cfg.base_level;
            is_ramp       = 1'b1;
        end else begin
            c_region_next = pwg_pkg::REGION_REST;
        end
        diff       = $signed({to_lvl[LB-1], to_lvl}) - $signed({c_from_next[LB-1], c_from_next});
        c_neg_next = diff[MB-1];
        c_mag_next = is_ramp ? (c_neg_next ? MB'(-diff) : MB'(diff)) : '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_region_reg <= c_region_next;
            c_t_reg      <= c_t_next;
            c_dur_reg    <= c_dur_next;
            c_from_reg   <= c_from_next;
            c_neg_reg    <= c_neg_next;
            c_mag_reg    <= c_mag_next;
        end
    end

    logic [MB+TB-1:0] prod;
    assign prod = c_mag_reg * c_t_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            d_word_reg.region <= c_region_reg;
            d_word_reg.dur    <= c_dur_reg;
            d_word_reg.from   <= c_from_reg;
            d_word_reg.neg    <= c_neg_reg;
            d_word_reg.rem    <= prod[MB+TB-1:MB];
            d_word_reg.low    <= prod[MB-1:0];
            d_word_reg.quo    <= '0;
        end
    end

    for (genvar i = 0; i < MB; i++) begin : g_div
        logic [TB:0]        tmp;
        pwg_pkg::div_word_t word_cur;
        logic               valid_cur;
        pwg_pkg::div_word_t word_next;

        if (i == 0) begin : g_head
            assign word_cur  = d_word_reg;
            assign valid_cur = d_valid_reg;
        end else begin : g_body
            assign word_cur  = word_reg[i];
            assign valid_cur = valid_reg[i];
        end

        always_comb begin
            tmp       = {word_cur.rem, word_cur.low[MB-1]};
            word_next = word_cur;
            word_next.low = {word_cur.low[MB-2:0], 1'b0};
            if (tmp >= {1'b0, word_cur.dur}) begin
                word_next.rem = TB'(tmp - {1'b0, word_cur.dur});
                word_next.quo = {word_cur.quo[MB-2:0], 1'b1};
            end else begin
                word_next.rem = tmp[TB-1:0];
                word_next.quo = {word_cur.quo[MB-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i+1] <= 1'b0;
            end else if (en) begin
                valid_reg[i+1] <= valid_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                word_reg[i+1] <= word_next;
            end
        end
    end

    logic [MB-1:0] from_ext;
    logic [MB-1:0] sum;
    assign from_ext = {word_reg[MB].from[LB-1], word_reg[MB].from};
    assign sum      = word_reg[MB].neg ? from_ext - word_reg[MB].quo
                                       : from_ext + word_reg[MB].quo;

    assign out_valid  = valid_reg[MB];
    assign out_level  = sum[LB-1:0];
    assign out_region = word_reg[MB].region;

endmodule

[hw/rtl/pulse_waveform_generator_core.sv]
// ----------------------------------------------------------------------------
// Pulse waveform generator core
// Trapezoidal periodic pulse level from a tick time stamp.
// ----------------------------------------------------------------------------
// Each word on the slave stream is a 32-bit unsigned time stamp. For every
// word the master stream returns one word with the signed 16-bit level in
// tdata and the region code in tuser.
// The pipeline is made of one input stage, 32 stages of the phase remainder
// by the period, four stages of region decode and multiply, 17 stages of the
// ramp divider and the output register. Unless the receiver stalls, one word
// enters and one leaves every cycle; the two one-bit-per-stage dividers set
// the depth. All stages advance together; when the receiver stalls a full
// output register, s_tready drops and every stage holds its word. Reset clears
// all valid bits and the configuration registers. The configuration port must
// be written only while the pipeline is empty; the block does not enforce it.
// ----------------------------------------------------------------------------
module pulse_waveform_generator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] time_tick
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] level
    output logic [2:0]  m_tuser    // [2:0] region
);

    localparam int TB = pwg_pkg::TIME_BITS;
    localparam int LB = pwg_pkg::LEVEL_BITS;

    pwg_pkg::cfg_t cfg_reg;
    logic          adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (pwg_pkg::reg_idx_t'(cfg_addr))
                pwg_pkg::REG_BASE_LEVEL:   cfg_reg.base_level   <= cfg_wdata[LB-1:0];
                pwg_pkg::REG_PEAK_LEVEL:   cfg_reg.peak_level   <= cfg_wdata[LB-1:0];
                pwg_pkg::REG_START_DELAY:  cfg_reg.start_delay  <= cfg_wdata[TB-1:0];
                pwg_pkg::REG_RISE_TICKS:   cfg_reg.rise_ticks   <= cfg_wdata[TB-1:0];
                pwg_pkg::REG_WIDTH_TICKS:  cfg_reg.width_ticks  <= cfg_wdata[TB-1:0];
                pwg_pkg::REG_FALL_TICKS:   cfg_reg.fall_ticks   <= cfg_wdata[TB-1:0];
                pwg_pkg::REG_PERIOD_TICKS: cfg_reg.period_ticks <= cfg_wdata[TB-1:0];
                default: ;
            endcase
        end
    end

    logic          m_valid_reg;
    logic [LB-1:0] m_level_reg;
    logic [2:0]    m_region_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    logic          in_valid_reg;
    logic          in_before_reg;
    logic [TB-1:0] in_ph_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_before_reg <= s_tdata[TB-1:0] < cfg_reg.start_delay;
            in_ph_reg     <= s_tdata[TB-1:0] - cfg_reg.start_delay;
        end
    end

    logic          w_valid;
    logic          w_before;
    logic [TB-1:0] w_phase;

    pwg_wrap u_wrap (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .cfg        (cfg_reg),
        .in_valid   (in_valid_reg),
        .in_before  (in_before_reg),
        .in_ph      (in_ph_reg),
        .out_valid  (w_valid),
        .out_before (w_before),
        .out_phase  (w_phase)
    );

    logic             r_valid;
    logic [LB-1:0]    r_level;
    pwg_pkg::region_t r_region;

    pwg_ramp u_ramp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .cfg        (cfg_reg),
        .in_valid   (w_valid),
        .in_before  (w_before),
        .in_phase   (w_phase),
        .out_valid  (r_valid),
        .out_level  (r_level),
        .out_region (r_region)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= r_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_level_reg  <= r_level;
            m_region_reg <= r_region;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_level_reg;
    assign m_tuser  = m_region_reg;

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted during output stall");

    a_region_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == pwg_pkg::REGION_DELAY || m_tuser == pwg_pkg::REGION_RISING
            || m_tuser == pwg_pkg::REGION_HIGH || m_tuser == pwg_pkg::REGION_FALLING
            || m_tuser == pwg_pkg::REGION_REST))
        else $error("region code out of range");

endmodule

[tb/sv/pwg_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pulse level checker
// Watches the configuration port and both streams of the pulse waveform
// generator, predicts level and region for every accepted time stamp and
// compares each returned word against the oldest prediction.
// ----------------------------------------------------------------------------
module pwg_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [2:0]  m_tuser,
    output int          fail_count,
    output int          pending_count,
    output int          seen_count
);

    typedef struct packed {
        logic [15:0]      level;
        pwg_pkg::region_t region;
    } level_word_t;

    logic signed [15:0] base_lvl, peak_lvl;
    logic [31:0] delay_t, rise_t, width_t, fall_t, period_t;
    level_word_t level_queue[$];

    function automatic logic [15:0] ramp_level(logic signed [15:0] from_lvl,
                                               logic signed [15:0] to_lvl,
                                               logic [31:0] t, logic [31:0] dur);
        logic signed [17:0] diff;
        logic [16:0]        mag;
        logic [48:0]        q;
        diff = to_lvl - from_lvl;
        mag = (diff < 0) ? 17'(-diff) : 17'(diff);
        q = ({32'd0, mag} * {17'd0, t}) / {17'd0, dur};
        if (diff < 0)
            return 16'(from_lvl - $signed({1'b0, q[16:0]}));
        return 16'(from_lvl + $signed({1'b0, q[16:0]}));
    endfunction

    function automatic level_word_t pulse_at(logic [31:0] tick);
        level_word_t r;
        logic [31:0] ph;
        if (tick < delay_t) begin
            r.level = base_lvl;
            r.region = pwg_pkg::REGION_DELAY;
            return r;
        end
        ph = tick - delay_t;
        if (period_t != 0)
            ph = ph % period_t;
        if (ph < rise_t) begin
            r.level = ramp_level(base_lvl, peak_lvl, ph, rise_t);
            r.region = pwg_pkg::REGION_RISING;
            return r;
        end
        ph = ph - rise_t;
        if (ph < width_t) begin
            r.level = peak_lvl;
            r.region = pwg_pkg::REGION_HIGH;
            return r;
        end
        ph = ph - width_t;
        if (ph < fall_t) begin
            r.level = ramp_level(peak_lvl, base_lvl, ph, fall_t);
            r.region = pwg_pkg::REGION_FALLING;
        end else begin
            r.level = base_lvl;
            r.region = pwg_pkg::REGION_REST;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        level_word_t want;
        if (!aresetn) begin
            base_lvl <= '0; peak_lvl <= '0; delay_t <= '0; rise_t <= '0;
            width_t <= '0; fall_t <= '0; period_t <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (pwg_pkg::reg_idx_t'(cfg_addr))
                    pwg_pkg::REG_BASE_LEVEL:   base_lvl <= cfg_wdata[15:0];
                    pwg_pkg::REG_PEAK_LEVEL:   peak_lvl <= cfg_wdata[15:0];
                    pwg_pkg::REG_START_DELAY:  delay_t <= cfg_wdata;
                    pwg_pkg::REG_RISE_TICKS:   rise_t <= cfg_wdata;
                    pwg_pkg::REG_WIDTH_TICKS:  width_t <= cfg_wdata;
                    pwg_pkg::REG_FALL_TICKS:   fall_t <= cfg_wdata;
                    pwg_pkg::REG_PERIOD_TICKS: period_t <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                level_queue.push_back(pulse_at(s_tdata));
            if (m_tvalid && m_tready) begin
                seen_count++;
                if (level_queue.size() == 0) begin
                    report_mismatch("word with no prediction waiting");
                end else begin
                    want = level_queue.pop_front();
                    if (m_tdata !== want.level)
                        report_mismatch($sformatf("level %0d, predicted %0d",
                            $signed(m_tdata), $signed(want.level)));
                    if (m_tuser !== want.region)
                        report_mismatch($sformatf("region %0d, predicted %0d",
                            m_tuser, want.region));
                end
            end
            pending_count <= level_queue.size();
        end
    end

    initial begin
        fail_count = 0;
        pending_count = 0;
        seen_count = 0;
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pulse waveform generator testbench
// Steps through several pulse shapes, from zero-length ramps and one-shot to
// full-range timing, sends directed and random time stamps with random
// gaps and receiver stalls, and takes the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    int          fail_count, pending_count, seen_count;
    longint      cycle_count = 0;
    int          sent_count = 0;
    bit          sending_done = 0;
    logic [31:0] shape[7];

    localparam int  PIPE_DEPTH = 55;
    localparam longint CYCLE_LIMIT = 400000;

    always #4 aclk = ~aclk;

    pulse_waveform_generator_core uut (.*);

    pwg_checker chk (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        int stall;
        stall = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0 || sending_done)
            stall = 0;
        if (stall != 0) begin
            m_tready <= 1'b0;
            repeat (stall) @(posedge aclk);
        end
        m_tready <= 1'b1;
    end

    task automatic write_reg(pwg_pkg::reg_idx_t idx, logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic load_shape();
        for (int i = 0; i < 7; i++)
            write_reg(pwg_pkg::reg_idx_t'(i), shape[i]);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_tick(logic [31:0] tick, bit with_gaps);
        int gap;
        gap = $urandom_range(0, 14);
        if (with_gaps && $urandom_range(0, 2) != 0 && gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tick;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [31:0] near_edge();
        logic [31:0] e;
        logic [31:0] p;
        p = shape[pwg_pkg::REG_PERIOD_TICKS];
        case ($urandom_range(0, 5))
            0: e = shape[pwg_pkg::REG_START_DELAY];
            1: e = shape[pwg_pkg::REG_START_DELAY] + shape[pwg_pkg::REG_RISE_TICKS];
            2: e = shape[pwg_pkg::REG_START_DELAY] + shape[pwg_pkg::REG_RISE_TICKS]
                   + shape[pwg_pkg::REG_WIDTH_TICKS];
            3: e = shape[pwg_pkg::REG_START_DELAY] + shape[pwg_pkg::REG_RISE_TICKS]
                   + shape[pwg_pkg::REG_WIDTH_TICKS] + shape[pwg_pkg::REG_FALL_TICKS];
            4: e = shape[pwg_pkg::REG_START_DELAY] + p * $urandom_range(1, 5);
            default: e = shape[pwg_pkg::REG_START_DELAY] + p - 1;
        endcase
        return e + $urandom_range(0, 6) - 3;
    endfunction

    task automatic random_shape(bit wide);
        shape[pwg_pkg::REG_BASE_LEVEL] = $urandom;
        shape[pwg_pkg::REG_PEAK_LEVEL] = $urandom;
        if (wide) begin
            for (int i = 2; i < 7; i++)
                shape[i] = $urandom;
        end else begin
            shape[pwg_pkg::REG_START_DELAY] = $urandom_range(0, 300);
            shape[pwg_pkg::REG_RISE_TICKS]  =
                $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 200);
            shape[pwg_pkg::REG_WIDTH_TICKS] = $urandom_range(0, 150);
            shape[pwg_pkg::REG_FALL_TICKS]  =
                $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 200);
            shape[pwg_pkg::REG_PERIOD_TICKS] =
                $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 700);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values: everything zero, one-shot, all ramps empty.
        send_tick(32'd0, 0);
        send_tick(32'hFFFF_FFFF, 0);
        drain();

        shape = '{32'h0000_8000, 32'h0000_7FFF, 32'd10, 32'd20, 32'd5, 32'd30, 32'd0};
        load_shape();
        for (int k = 0; k < 8; k++)
            send_tick(k * 10 + (k % 3), 0);
        send_tick(32'hFFFF_FFFF, 0);
        drain();

        shape = '{32'h0000_7FFF, 32'h0000_8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        load_shape();
        send_tick(32'hFFFF_FFFE, 0);
        send_tick(32'hFFFF_FFFF, 0);
        drain();

        shape = '{32'h0000_0000, 32'h0000_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'h8000_0000, 32'hFFFF_FFFF};
        load_shape();
        for (int k = 0; k < 8; k++)
            send_tick(32'h2000_0000 * k + k, 0);
        drain();

        for (int phase = 0; phase < 40; phase++) begin
            random_shape(phase % 8 == 7);
            load_shape();
            for (int k = 0; k < 45; k++) begin
                if ($urandom_range(0, 9) < 6)
                    send_tick(near_edge(), phase % 5 != 0);
                else
                    send_tick($urandom, phase % 5 != 0);
            end
            drain();
        end

        sending_done = 1;
        repeat (PIPE_DEPTH + 10) @(posedge aclk);
        $display("Sent %0d time stamps over 43 pulse shapes, %0d levels returned.",
                 sent_count, seen_count);
        $display("Shapes covered one-shot, zero ramps, and full-range timing.");
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
